// ===== rtl/hba_pkg.sv =====
`default_nettype none

package hba_pkg;

    localparam int WORD_WIDTH  = 32;
    localparam int MAX_BUCKETS = 64;

    localparam int LEADER_W = 32;
    localparam int MAXD_W   = 6;
    localparam int LIMIT_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 16;

    localparam int IDX_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int TOT_W   = $clog2(MAX_BUCKETS + 1);
    localparam int DIST_W  = $clog2(WORD_WIDTH + 1);
    localparam int DCMP_W  = (DIST_W > MAXD_W) ? DIST_W : MAXD_W;
    localparam int CMP_W   = (TOT_W > LIMIT_W) ? TOT_W : LIMIT_W;

    localparam logic [FILL_W-1:0] FILL_TOP = '1;

    localparam logic [1:0] REG_MAX_DISTANCE = 2'd0;
    localparam logic [1:0] REG_BUCKET_LIMIT = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ROOM     = 3'd0,
        ST_NEW      = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_UNFIT    = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    // Search token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic                  valid;
        logic [WORD_WIDTH-1:0] word;
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic                  have_full;
        logic [IDX_W-1:0]      full_idx;
    } tok_t;

    // Settings and write commands broadcast from the controller to every cell.
    typedef struct packed {
        logic [TOT_W-1:0]      total;
        logic [MAXD_W-1:0]     max_distance;
        logic [LIMIT_W-1:0]    bucket_limit;
        logic                  wr_en;
        logic                  wr_new;
        logic [IDX_W-1:0]      wr_idx;
        logic [WORD_WIDTH-1:0] word;
    } bus_t;

    function automatic logic [DIST_W-1:0] popcount(input logic [WORD_WIDTH-1:0] x);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_WIDTH; i++) begin
            n = n + DIST_W'(x[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hamming_bucket_assign.sv =====
`default_nettype none

// Places each incoming word, where it can, into a bucket of words that lie
// within a Hamming distance limit of the bucket's representative. Each bucket
// lives in one cell of a row; an assign beat sends a search token down the
// row, one cell per cycle, so the length of the cell row sets how long an
// assign takes from acceptance to its result beat; a clear skips the row.
// A new beat is taken once the previous one has its result in the output
// register, even while that result still waits to be read.
// Configuration writes go through cfg_* (index 0 distance limit, index 1
// bucket limit) and should only be issued while the block is idle.

module hamming_bucket_assign (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [hba_pkg::LEADER_W-1:0] s_axis_tdata,  // [31:0] leader_word
    input  wire logic                         s_axis_tuser,  // [0] action

    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // [5:0] bucket_index, [7:6] zero
    output logic [hba_pkg::STATUS_W-1:0]      m_axis_tuser,  // [2:0] status

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [hba_pkg::LIMIT_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [hba_pkg::MAXD_W-1:0]     max_distance_reg;
    logic [hba_pkg::LIMIT_W-1:0]    bucket_limit_reg;
    logic [hba_pkg::TOT_W-1:0]      total_reg;
    logic [hba_pkg::WORD_WIDTH-1:0] word_reg;
    logic                           wr_en_reg;
    logic                           wr_new_reg;
    logic [hba_pkg::IDX_W-1:0]      wr_idx_reg;
    logic [hba_pkg::INDEX_W-1:0]    res_idx_reg;
    hba_pkg::status_t               res_status_reg;
    logic                           m_valid_reg;
    logic [hba_pkg::INDEX_W-1:0]    m_idx_reg;
    hba_pkg::status_t               m_status_reg;

    hba_pkg::tok_t chain [hba_pkg::MAX_BUCKETS+1];
    hba_pkg::bus_t bus;
    hba_pkg::tok_t last_tok;

    logic s_beat;
    logic can_open;
    logic out_load;
    logic wr_start;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb begin
        chain[0]           = '0;
        chain[0].valid     = s_beat && !s_axis_tuser;
        chain[0].word      = hba_pkg::WORD_WIDTH'(s_axis_tdata);
    end

    assign bus.total        = total_reg;
    assign bus.max_distance = max_distance_reg;
    assign bus.bucket_limit = bucket_limit_reg;
    assign bus.wr_en        = wr_en_reg;
    assign bus.wr_new       = wr_new_reg;
    assign bus.wr_idx       = wr_idx_reg;
    assign bus.word         = word_reg;

    for (genvar g = 0; g < hba_pkg::MAX_BUCKETS; g++) begin : g_cell
        hba_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (hba_pkg::IDX_W'(g)),
            .tok_in   (chain[g]),
            .bus      (bus),
            .tok_out  (chain[g+1])
        );
    end

    assign last_tok = chain[hba_pkg::MAX_BUCKETS];
    assign can_open = (hba_pkg::CMP_W'(total_reg) < hba_pkg::CMP_W'(bucket_limit_reg))
                   && (total_reg < hba_pkg::TOT_W'(hba_pkg::MAX_BUCKETS));
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_axis_tready);
    assign wr_start = (state_reg == S_WALK) && last_tok.valid && !last_tok.hit
                   && (can_open || last_tok.have_full);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            max_distance_reg <= hba_pkg::MAXD_W'(1);
            bucket_limit_reg <= hba_pkg::LIMIT_W'(64);
            total_reg        <= '0;
            wr_en_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            wr_en_reg <= wr_start;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    hba_pkg::REG_MAX_DISTANCE: max_distance_reg <= cfg_data[hba_pkg::MAXD_W-1:0];
                    hba_pkg::REG_BUCKET_LIMIT: bucket_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_beat) begin
                        word_reg <= hba_pkg::WORD_WIDTH'(s_axis_tdata);
                        if (s_axis_tuser) begin
                            total_reg      <= '0;
                            res_idx_reg    <= '0;
                            res_status_reg <= hba_pkg::ST_CLEARED;
                            state_reg      <= S_DONE;
                        end else begin
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (last_tok.valid) begin
                        if (last_tok.hit) begin
                            res_idx_reg    <= hba_pkg::INDEX_W'(last_tok.hit_idx);
                            res_status_reg <= hba_pkg::ST_ROOM;
                        end else if (can_open) begin
                            res_idx_reg    <= hba_pkg::INDEX_W'(total_reg);
                            res_status_reg <= hba_pkg::ST_NEW;
                            wr_new_reg     <= 1'b1;
                            wr_idx_reg     <= hba_pkg::IDX_W'(total_reg);
                            total_reg      <= total_reg + 1'b1;
                        end else if (last_tok.have_full) begin
                            res_idx_reg    <= hba_pkg::INDEX_W'(last_tok.full_idx);
                            res_status_reg <= hba_pkg::ST_OVERFLOW;
                            wr_new_reg     <= 1'b0;
                            wr_idx_reg     <= last_tok.full_idx;
                        end else begin
                            res_idx_reg    <= '0;
                            res_status_reg <= hba_pkg::ST_UNFIT;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Wait for the output register to free up before handing over.
                    if (out_load) begin
                        m_idx_reg    <= res_idx_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = 8'(m_idx_reg);
    assign m_axis_tuser  = m_status_reg;

endmodule

`default_nettype wire

// ===== rtl/hba_cell.sv =====
`default_nettype none

module hba_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [hba_pkg::IDX_W-1:0] cell_idx,
    input  wire hba_pkg::tok_t     tok_in,
    input  wire hba_pkg::bus_t     bus,
    output hba_pkg::tok_t          tok_out
);

    logic [hba_pkg::WORD_WIDTH-1:0] rep_reg;
    logic [hba_pkg::WORD_WIDTH-1:0] rep_next;
    logic [hba_pkg::FILL_W-1:0]     fill_reg;
    logic [hba_pkg::FILL_W-1:0]     fill_next;
    logic [hba_pkg::FILL_W-1:0]     fill_bumped;
    hba_pkg::tok_t                  tok_reg;
    hba_pkg::tok_t                  tok_next;

    logic [hba_pkg::DIST_W-1:0] ham_dist;
    logic                       is_open;
    logic                       in_range;
    logic                       has_room;

    assign ham_dist = hba_pkg::popcount(rep_reg ^ tok_in.word);
    assign is_open  = hba_pkg::TOT_W'(cell_idx) < bus.total;
    assign in_range = hba_pkg::DCMP_W'(ham_dist) <= hba_pkg::DCMP_W'(bus.max_distance);
    assign has_room = fill_reg < hba_pkg::FILL_W'(bus.bucket_limit);
    assign fill_bumped = (fill_reg == hba_pkg::FILL_TOP) ? fill_reg : fill_reg + 1'b1;

    always_comb begin
        rep_next  = rep_reg;
        fill_next = fill_reg;
        tok_next  = tok_in;
        if (tok_in.valid && is_open && in_range && !tok_in.hit) begin
            if (has_room) begin
                fill_next        = fill_bumped;
                tok_next.hit     = 1'b1;
                tok_next.hit_idx = cell_idx;
            end else if (!tok_in.have_full) begin
                tok_next.have_full = 1'b1;
                tok_next.full_idx  = cell_idx;
            end
        end
        // Controller writes only land while no token is in the row.
        if (bus.wr_en && (bus.wr_idx == cell_idx)) begin
            if (bus.wr_new) begin
                rep_next  = bus.word;
                fill_next = '0;
            end else begin
                fill_next = fill_bumped;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rep_reg  <= rep_next;
        fill_reg <= fill_next;
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
